FILE: design/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master package
// Shared types and codes of the single register read/write I2C master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int TPU_WIDTH   = 10;   // ticks per microsecond register
   localparam int LIMIT_WIDTH = 8;    // acknowledge poll limit register
   localparam int CSR_WIDTH   = 10;   // widest register
   localparam int DELAY_WIDTH = 12;   // holds 4 * 1023 - 1
   localparam int BYTE_WIDTH  = 8;

   localparam logic [TPU_WIDTH-1:0]   TPU_RESET   = 10'd1;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 8'd250;
   localparam logic [BYTE_WIDTH-1:0]  MSB_MASK    = 8'h80;

   // Request codes.
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Register indexes.
   localparam logic CSR_TICKS_PER_US   = 1'b0;
   localparam logic CSR_ACK_POLL_LIMIT = 1'b1;

   // Byte steps of a transaction.
   localparam logic [1:0] STEP_DEVICE   = 2'd0;
   localparam logic [1:0] STEP_REGISTER = 2'd1;
   localparam logic [1:0] STEP_THIRD    = 2'd2;
   localparam logic [1:0] STEP_LAST     = 2'd3;

   typedef enum logic [17:0] {
      PH_IDLE        = 18'b000000000000000001,
      PH_START_FALL  = 18'b000000000000000010,
      PH_START_CLAMP = 18'b000000000000000100,
      PH_START_RISE  = 18'b000000000000001000,
      PH_BIT_SET     = 18'b000000000000010000,
      PH_BIT_HIGH    = 18'b000000000000100000,
      PH_BIT_LOW     = 18'b000000000001000000,
      PH_ACK_REL     = 18'b000000000010000000,
      PH_ACK_HIGH    = 18'b000000000100000000,
      PH_ACK_POLL    = 18'b000000001000000000,
      PH_READ_LOW    = 18'b000000010000000000,
      PH_READ_HIGH   = 18'b000000100000000000,
      PH_NACK_LOW    = 18'b000001000000000000,
      PH_NACK_HIGH   = 18'b000010000000000000,
      PH_NACK_END    = 18'b000100000000000000,
      PH_STOP_LOW    = 18'b001000000000000000,
      PH_STOP_HIGH   = 18'b010000000000000000,
      PH_FINISH      = 18'b100000000000000000
   } phase_type;

   // Line levels: scl is the driven clock, sda_high means SDA is released.
   typedef struct packed {
      logic sda_high;
      logic scl;
   } lines_type;

endpackage

FILE: design/i2c_master_register_access.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master for single register access
// Bit-banged I2C master that writes or reads one device register, stepped
// by one tick beat per clock while its rsp beats are taken.
// ----------------------------------------------------------------------------
// Every accepted req beat is one tick of bus time and gives exactly one rsp
// beat with the line levels and status after that tick. The block takes one
// beat per clock cycle while rsp beats are taken; a beat is first held in an
// input register, and the controller state, which is also the rsp register,
// updates from it when its rsp beat has somewhere to go. Bus
// timing is counted in ticks: each phase takes one tick plus a hold of
// n * ticks_per_microsecond - 1 ticks for a hold of n microsecond units.
// Requests that arrive while a transaction is running are ignored.
module i2c_master_register_access (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_func,
   input  logic [i2cm_pkg::BYTE_WIDTH-1:0]     req_device_address,
   input  logic [i2cm_pkg::BYTE_WIDTH-1:0]     req_register_address,
   input  logic [i2cm_pkg::BYTE_WIDTH-1:0]     req_write_data,
   input  logic                                req_sda_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_scl_level,
   output logic                                rsp_sda_pull_low,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [i2cm_pkg::BYTE_WIDTH-1:0]     rsp_read_data,
   output logic                                rsp_ack_failed,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [i2cm_pkg::CSR_WIDTH-1:0]      csr_write_data
);

   localparam int BW = i2cm_pkg::BYTE_WIDTH;
   localparam int DW = i2cm_pkg::DELAY_WIDTH;

   // Configuration registers.
   logic [i2cm_pkg::TPU_WIDTH-1:0]   tpu_ff;
   logic [i2cm_pkg::LIMIT_WIDTH-1:0] limit_ff;

   // Input register.
   logic          in_valid_ff;
   logic [1:0]    func_ff;
   logic [BW-1:0] dev_in_ff;
   logic [BW-1:0] reg_in_ff;
   logic [BW-1:0] data_in_ff;
   logic          sda_ff;

   // Controller state; it doubles as the rsp register.
   i2cm_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          step_ff, step_in;
   logic [3:0]          bit_ff, bit_in;
   logic [BW-1:0]       shift_ff, shift_in;
   logic [DW-1:0]       delay_ff, delay_in;
   logic [i2cm_pkg::LIMIT_WIDTH-1:0] poll_ff, poll_in;
   logic                is_read_ff, is_read_in;
   logic [BW-1:0]       dev_ff, dev_in;
   logic [BW-1:0]       regaddr_ff, regaddr_in;
   logic [BW-1:0]       data_ff, data_in;
   logic [BW-1:0]       received_ff, received_in;
   logic                error_ff, error_in;
   i2cm_pkg::lines_type lines_ff, lines_in;
   logic                done_ff, done_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                           advance;
   logic [i2cm_pkg::TPU_WIDTH-1:0] tpu_eff;
   logic [DW-1:0]                  dly1, dly2, dly4;
   logic [1:0]                     step_inc;
   logic [3:0]                     bit_inc;

   function automatic logic [BW-1:0] byte_for_step(
      input logic [1:0]    step,
      input logic          rd,
      input logic [BW-1:0] dev,
      input logic [BW-1:0] regaddr,
      input logic [BW-1:0] data
   );
      logic [BW-1:0] value;
      case (step)
         i2cm_pkg::STEP_DEVICE:   value = dev;
         i2cm_pkg::STEP_REGISTER: value = regaddr;
         i2cm_pkg::STEP_THIRD:    value = rd ? dev + BW'(1) : data;
         default:                 value = '0;
      endcase
      return value;
   endfunction

   // The state may only move when its rsp beat has somewhere to go.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign tpu_eff = (tpu_ff == '0) ? i2cm_pkg::TPU_WIDTH'(1) : tpu_ff;
   assign dly1    = DW'(tpu_eff) - DW'(1);
   assign dly2    = DW'({tpu_eff, 1'b0}) - DW'(1);
   assign dly4    = DW'({tpu_eff, 2'b00}) - DW'(1);
   assign step_inc = step_ff + 2'd1;
   assign bit_inc  = bit_ff + 4'd1;

   always_comb begin
      phase_in    = phase_ff;
      step_in     = step_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      delay_in    = delay_ff;
      poll_in     = poll_ff;
      is_read_in  = is_read_ff;
      dev_in      = dev_ff;
      regaddr_in  = regaddr_ff;
      data_in     = data_ff;
      received_in = received_ff;
      error_in    = error_ff;
      lines_in    = lines_ff;
      done_in     = 1'b0;

      if (phase_ff == i2cm_pkg::PH_IDLE) begin
         if (func_ff inside {i2cm_pkg::FUNC_WRITE, i2cm_pkg::FUNC_READ}) begin
            is_read_in = (func_ff == i2cm_pkg::FUNC_READ);
            dev_in     = dev_in_ff;
            regaddr_in = reg_in_ff;
            data_in    = data_in_ff;
            error_in   = 1'b0;
            step_in    = i2cm_pkg::STEP_DEVICE;
            lines_in   = '{sda_high: 1'b1, scl: 1'b1};
            phase_in   = i2cm_pkg::PH_START_FALL;
            delay_in   = dly4;
         end
      end else if (delay_ff != '0) begin
         delay_in = delay_ff - DW'(1);
      end else begin
         case (phase_ff)
            i2cm_pkg::PH_START_RISE: begin
               lines_in = '{sda_high: 1'b1, scl: 1'b1};
               phase_in = i2cm_pkg::PH_START_FALL;
               delay_in = dly4;
            end
            i2cm_pkg::PH_START_FALL: begin
               lines_in = '{sda_high: 1'b0, scl: 1'b1};
               phase_in = i2cm_pkg::PH_START_CLAMP;
               delay_in = dly4;
            end
            i2cm_pkg::PH_START_CLAMP: begin
               lines_in.scl = 1'b0;
               shift_in = byte_for_step(step_ff, is_read_ff, dev_ff, regaddr_ff, data_ff);
               bit_in   = '0;
               phase_in = i2cm_pkg::PH_BIT_SET;
               delay_in = '0;
            end
            i2cm_pkg::PH_BIT_SET: begin
               lines_in = '{sda_high: ((shift_ff & i2cm_pkg::MSB_MASK) != '0), scl: 1'b0};
               shift_in = {shift_ff[BW-2:0], 1'b0};
               phase_in = i2cm_pkg::PH_BIT_HIGH;
               delay_in = dly2;
            end
            i2cm_pkg::PH_BIT_HIGH: begin
               lines_in.scl = 1'b1;
               phase_in = i2cm_pkg::PH_BIT_LOW;
               delay_in = dly2;
            end
            i2cm_pkg::PH_BIT_LOW: begin
               lines_in.scl = 1'b0;
               bit_in   = bit_inc;
               phase_in = (bit_inc >= 4'd8) ? i2cm_pkg::PH_ACK_REL : i2cm_pkg::PH_BIT_SET;
               delay_in = dly2;
            end
            i2cm_pkg::PH_ACK_REL: begin
               lines_in = '{sda_high: 1'b1, scl: 1'b0};
               phase_in = i2cm_pkg::PH_ACK_HIGH;
               delay_in = dly1;
            end
            i2cm_pkg::PH_ACK_HIGH: begin
               lines_in.scl = 1'b1;
               poll_in  = '0;
               phase_in = i2cm_pkg::PH_ACK_POLL;
               delay_in = dly1;
            end
            i2cm_pkg::PH_ACK_POLL: begin
               if (!sda_ff) begin
                  lines_in.scl = 1'b0;
                  step_in = step_inc;
                  // A read turns around with a repeated start after the
                  // register byte and then clocks in the data byte.
                  if (is_read_ff) begin
                     if (step_inc == i2cm_pkg::STEP_REGISTER) begin
                        shift_in = byte_for_step(step_inc, is_read_ff, dev_ff,
                                                 regaddr_ff, data_ff);
                        bit_in   = '0;
                        phase_in = i2cm_pkg::PH_BIT_SET;
                     end else if (step_inc == i2cm_pkg::STEP_THIRD) begin
                        phase_in = i2cm_pkg::PH_START_RISE;
                     end else begin
                        bit_in   = '0;
                        shift_in = '0;
                        phase_in = i2cm_pkg::PH_READ_LOW;
                     end
                  end else if (step_inc != i2cm_pkg::STEP_LAST) begin
                     shift_in = byte_for_step(step_inc, is_read_ff, dev_ff,
                                              regaddr_ff, data_ff);
                     bit_in   = '0;
                     phase_in = i2cm_pkg::PH_BIT_SET;
                  end else begin
                     phase_in = i2cm_pkg::PH_STOP_LOW;
                  end
                  delay_in = '0;
               end else if (poll_ff >= limit_ff) begin
                  error_in = 1'b1;
                  phase_in = i2cm_pkg::PH_STOP_LOW;
                  delay_in = '0;
               end else begin
                  poll_in = poll_ff + 8'd1;
               end
            end
            i2cm_pkg::PH_READ_LOW: begin
               lines_in = '{sda_high: 1'b1, scl: 1'b0};
               phase_in = i2cm_pkg::PH_READ_HIGH;
               delay_in = dly2;
            end
            i2cm_pkg::PH_READ_HIGH: begin
               lines_in.scl = 1'b1;
               shift_in = {shift_ff[BW-2:0], sda_ff};
               bit_in   = bit_inc;
               phase_in = (bit_inc >= 4'd8) ? i2cm_pkg::PH_NACK_LOW : i2cm_pkg::PH_READ_LOW;
               delay_in = dly1;
            end
            i2cm_pkg::PH_NACK_LOW: begin
               received_in = shift_ff;
               lines_in = '{sda_high: 1'b1, scl: 1'b0};
               phase_in = i2cm_pkg::PH_NACK_HIGH;
               delay_in = dly2;
            end
            i2cm_pkg::PH_NACK_HIGH: begin
               lines_in.scl = 1'b1;
               phase_in = i2cm_pkg::PH_NACK_END;
               delay_in = dly2;
            end
            i2cm_pkg::PH_NACK_END: begin
               lines_in.scl = 1'b0;
               phase_in = i2cm_pkg::PH_STOP_LOW;
               delay_in = '0;
            end
            i2cm_pkg::PH_STOP_LOW: begin
               lines_in = '{sda_high: 1'b0, scl: 1'b0};
               phase_in = i2cm_pkg::PH_STOP_HIGH;
               delay_in = dly4;
            end
            i2cm_pkg::PH_STOP_HIGH: begin
               lines_in = '{sda_high: 1'b1, scl: 1'b1};
               phase_in = i2cm_pkg::PH_FINISH;
               delay_in = dly4;
            end
            i2cm_pkg::PH_FINISH: begin
               phase_in = i2cm_pkg::PH_IDLE;
               delay_in = '0;
               done_in  = 1'b1;
            end
            default: begin
               phase_in = i2cm_pkg::PH_IDLE;
               delay_in = '0;
            end
         endcase
      end
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff   <= i2cm_pkg::TPU_RESET;
         limit_ff <= i2cm_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            i2cm_pkg::CSR_TICKS_PER_US:   tpu_ff   <= csr_write_data[i2cm_pkg::TPU_WIDTH-1:0];
            i2cm_pkg::CSR_ACK_POLL_LIMIT: limit_ff <= csr_write_data[i2cm_pkg::LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff    <= req_func;
         dev_in_ff  <= req_device_address;
         reg_in_ff  <= req_register_address;
         data_in_ff <= req_write_data;
         sda_ff     <= req_sda_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= i2cm_pkg::PH_IDLE;
         step_ff     <= '0;
         bit_ff      <= '0;
         shift_ff    <= '0;
         delay_ff    <= '0;
         poll_ff     <= '0;
         is_read_ff  <= 1'b0;
         dev_ff      <= '0;
         regaddr_ff  <= '0;
         data_ff     <= '0;
         received_ff <= '0;
         error_ff    <= 1'b0;
         lines_ff    <= '{sda_high: 1'b1, scl: 1'b1};
         done_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         step_ff     <= step_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         delay_ff    <= delay_in;
         poll_ff     <= poll_in;
         is_read_ff  <= is_read_in;
         dev_ff      <= dev_in;
         regaddr_ff  <= regaddr_in;
         data_ff     <= data_in;
         received_ff <= received_in;
         error_ff    <= error_in;
         lines_ff    <= lines_in;
         done_ff     <= done_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_level    = lines_ff.scl;
   assign rsp_sda_pull_low = !lines_ff.sda_high;
   assign rsp_busy_res     = (phase_ff != i2cm_pkg::PH_IDLE);
   assign rsp_done_res     = done_ff;
   assign rsp_read_data    = received_ff;
   assign rsp_ack_failed   = error_ff;

   // An idle bus always has both lines released.
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      !rsp_busy_res |-> (rsp_scl_level && !rsp_sda_pull_low))
      else $error("bus lines not released while idle");

   // A finishing beat reports the controller already idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // Polling never runs past the configured limit.
   a_poll_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == i2cm_pkg::PH_ACK_POLL) |-> (poll_ff <= limit_ff))
      else $error("acknowledge poll count beyond limit");

   // The state stands still while a result waits to be taken.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(phase_ff) && $stable(delay_ff)))
      else $error("controller state moved under a stalled result");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench of the single register I2C master
// Streams tick beats into the master and checks every status beat against a
// tick-by-tick model of the bus sequencer. Well-formed register writes and reads
// are driven by a simple device that acknowledges, stalls or never answers.
// Requests made while busy, unused codes, raw noise and extreme settings are
// mixed in. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 400;
   localparam int HOLD_AFTER     = 700;

   typedef enum logic [1:0] {
      KIND_REQUEST,
      KIND_DEVICE,
      KIND_RAW
   } item_kind_type;

   typedef enum logic [1:0] {
      ACK_AT_ONCE,
      ACK_LATE,
      ACK_NEVER
   } ack_style_type;

   typedef struct packed {
      item_kind_type                     kind;
      logic [1:0]                        func;
      logic [i2cm_pkg::BYTE_WIDTH-1:0]   device_address;
      logic [i2cm_pkg::BYTE_WIDTH-1:0]   register_address;
      logic [i2cm_pkg::BYTE_WIDTH-1:0]   write_data;
      logic                              sda;
   } tick_item_type;

   typedef struct packed {
      logic                              scl;
      logic                              sda_pull_low;
      logic                              busy;
      logic                              done;
      logic [i2cm_pkg::BYTE_WIDTH-1:0]   read_data;
      logic                              ack_failed;
   } bus_status_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [1:0]                        req_func = i2cm_pkg::FUNC_TICK;
   logic [i2cm_pkg::BYTE_WIDTH-1:0]   req_device_address = '0;
   logic [i2cm_pkg::BYTE_WIDTH-1:0]   req_register_address = '0;
   logic [i2cm_pkg::BYTE_WIDTH-1:0]   req_write_data = '0;
   logic                              req_sda_sample = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_scl_level;
   logic                              rsp_sda_pull_low;
   logic                              rsp_busy_res;
   logic                              rsp_done_res;
   logic [i2cm_pkg::BYTE_WIDTH-1:0]   rsp_read_data;
   logic                              rsp_ack_failed;
   logic                              csr_write_enable = 1'b0;
   logic                              csr_index = i2cm_pkg::CSR_TICKS_PER_US;
   logic [i2cm_pkg::CSR_WIDTH-1:0]    csr_write_data = '0;

   i2c_master_register_access i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_device_address   (req_device_address),
      .req_register_address (req_register_address),
      .req_write_data       (req_write_data),
      .req_sda_sample       (req_sda_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_scl_level        (rsp_scl_level),
      .rsp_sda_pull_low     (rsp_sda_pull_low),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_read_data        (rsp_read_data),
      .rsp_ack_failed       (rsp_ack_failed),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always #5 clock = ~clock;

   // Stimulus bookkeeping.
   tick_item_type    pending_ticks[$];
   bus_status_type   expected_status[$];
   int               ticks_queued = 0;
   int               mismatches = 0;
   logic             steady = 1'b0;
   ack_style_type    device_ack = ACK_AT_ONCE;

   // Model of the master: settings, sequencer state and line levels.
   logic [i2cm_pkg::TPU_WIDTH-1:0]    tpu_setting = i2cm_pkg::TPU_RESET;
   logic [i2cm_pkg::LIMIT_WIDTH-1:0]  poll_limit_setting = i2cm_pkg::LIMIT_RESET;
   i2cm_pkg::phase_type               master_phase = i2cm_pkg::PH_IDLE;
   logic [2:0]                        byte_index = '0;
   logic [3:0]                        bit_index = '0;
   logic [i2cm_pkg::BYTE_WIDTH-1:0]   bit_shift = '0;
   logic [13:0]                       hold_ticks = '0;
   logic [7:0]                        poll_count = '0;
   logic [1:0]                        held_func = i2cm_pkg::FUNC_TICK;
   logic [i2cm_pkg::BYTE_WIDTH-1:0]   held_device = '0;
   logic [i2cm_pkg::BYTE_WIDTH-1:0]   held_register = '0;
   logic [i2cm_pkg::BYTE_WIDTH-1:0]   held_data = '0;
   logic [i2cm_pkg::BYTE_WIDTH-1:0]   received_byte = '0;
   logic                              ack_timed_out = 1'b0;
   logic                              scl_out = 1'b1;
   logic                              sda_released = 1'b1;

   function automatic void enter_phase(input i2cm_pkg::phase_type next, input int units);
      logic [31:0] span;
      span = (units * ((tpu_setting == 0) ? 1 : int'(tpu_setting))) - 1;
      master_phase = next;
      hold_ticks = (units == 0) ? 14'd0 : span[13:0];
   endfunction

   function automatic void load_byte();
      case (byte_index)
         i2cm_pkg::STEP_DEVICE:   bit_shift = held_device;
         i2cm_pkg::STEP_REGISTER: bit_shift = held_register;
         i2cm_pkg::STEP_THIRD:
            bit_shift = (held_func == i2cm_pkg::FUNC_READ) ? held_device + 8'd1 : held_data;
         default:                 bit_shift = '0;
      endcase
      bit_index = '0;
      enter_phase(i2cm_pkg::PH_BIT_SET, 0);
   endfunction

   function automatic void raise_for_start();
      scl_out = 1'b1;
      sda_released = 1'b1;
      enter_phase(i2cm_pkg::PH_START_FALL, 4);
   endfunction

   function automatic void next_byte();
      byte_index = byte_index + 3'd1;
      if (held_func == i2cm_pkg::FUNC_READ) begin
         // A read turns around after the register byte with a repeated START.
         if (byte_index == i2cm_pkg::STEP_REGISTER) begin
            load_byte();
         end else if (byte_index == i2cm_pkg::STEP_THIRD) begin
            enter_phase(i2cm_pkg::PH_START_RISE, 0);
         end else begin
            bit_index = '0;
            bit_shift = '0;
            enter_phase(i2cm_pkg::PH_READ_LOW, 0);
         end
      end else if (byte_index < i2cm_pkg::STEP_LAST) begin
         load_byte();
      end else begin
         enter_phase(i2cm_pkg::PH_STOP_LOW, 0);
      end
   endfunction

   // Advances the model by one tick and returns the status after it.
   function automatic bus_status_type advance_master(input tick_item_type t);
      bus_status_type st;
      logic finished;
      finished = 1'b0;
      if (master_phase == i2cm_pkg::PH_IDLE) begin
         if (t.func == i2cm_pkg::FUNC_WRITE || t.func == i2cm_pkg::FUNC_READ) begin
            held_func = t.func;
            held_device = t.device_address;
            held_register = t.register_address;
            held_data = t.write_data;
            ack_timed_out = 1'b0;
            byte_index = '0;
            raise_for_start();
         end
      end else if (hold_ticks != 0) begin
         hold_ticks = hold_ticks - 14'd1;
      end else begin
         case (master_phase)
            i2cm_pkg::PH_START_RISE: raise_for_start();
            i2cm_pkg::PH_START_FALL: begin
               scl_out = 1'b1;
               sda_released = 1'b0;
               enter_phase(i2cm_pkg::PH_START_CLAMP, 4);
            end
            i2cm_pkg::PH_START_CLAMP: begin
               scl_out = 1'b0;
               load_byte();
            end
            i2cm_pkg::PH_BIT_SET: begin
               scl_out = 1'b0;
               sda_released = (bit_shift & i2cm_pkg::MSB_MASK) != 0;
               bit_shift = bit_shift << 1;
               enter_phase(i2cm_pkg::PH_BIT_HIGH, 2);
            end
            i2cm_pkg::PH_BIT_HIGH: begin
               scl_out = 1'b1;
               enter_phase(i2cm_pkg::PH_BIT_LOW, 2);
            end
            i2cm_pkg::PH_BIT_LOW: begin
               scl_out = 1'b0;
               bit_index = bit_index + 4'd1;
               enter_phase((bit_index >= 8) ? i2cm_pkg::PH_ACK_REL : i2cm_pkg::PH_BIT_SET, 2);
            end
            i2cm_pkg::PH_ACK_REL: begin
               scl_out = 1'b0;
               sda_released = 1'b1;
               enter_phase(i2cm_pkg::PH_ACK_HIGH, 1);
            end
            i2cm_pkg::PH_ACK_HIGH: begin
               scl_out = 1'b1;
               poll_count = '0;
               enter_phase(i2cm_pkg::PH_ACK_POLL, 1);
            end
            i2cm_pkg::PH_ACK_POLL: begin
               if (!t.sda) begin
                  scl_out = 1'b0;
                  next_byte();
               end else if (poll_count >= poll_limit_setting) begin
                  ack_timed_out = 1'b1;
                  enter_phase(i2cm_pkg::PH_STOP_LOW, 0);
               end else begin
                  poll_count = poll_count + 8'd1;
               end
            end
            i2cm_pkg::PH_READ_LOW: begin
               scl_out = 1'b0;
               sda_released = 1'b1;
               enter_phase(i2cm_pkg::PH_READ_HIGH, 2);
            end
            i2cm_pkg::PH_READ_HIGH: begin
               scl_out = 1'b1;
               bit_shift = {bit_shift[6:0], t.sda};
               bit_index = bit_index + 4'd1;
               enter_phase((bit_index >= 8) ? i2cm_pkg::PH_NACK_LOW : i2cm_pkg::PH_READ_LOW,
                           1);
            end
            i2cm_pkg::PH_NACK_LOW: begin
               received_byte = bit_shift;
               scl_out = 1'b0;
               sda_released = 1'b1;
               enter_phase(i2cm_pkg::PH_NACK_HIGH, 2);
            end
            i2cm_pkg::PH_NACK_HIGH: begin
               scl_out = 1'b1;
               enter_phase(i2cm_pkg::PH_NACK_END, 2);
            end
            i2cm_pkg::PH_NACK_END: begin
               scl_out = 1'b0;
               enter_phase(i2cm_pkg::PH_STOP_LOW, 0);
            end
            i2cm_pkg::PH_STOP_LOW: begin
               scl_out = 1'b0;
               sda_released = 1'b0;
               enter_phase(i2cm_pkg::PH_STOP_HIGH, 4);
            end
            i2cm_pkg::PH_STOP_HIGH: begin
               scl_out = 1'b1;
               sda_released = 1'b1;
               enter_phase(i2cm_pkg::PH_FINISH, 4);
            end
            i2cm_pkg::PH_FINISH: begin
               master_phase = i2cm_pkg::PH_IDLE;
               hold_ticks = '0;
               finished = 1'b1;
            end
            default: begin
               master_phase = i2cm_pkg::PH_IDLE;
               hold_ticks = '0;
            end
         endcase
      end
      st.scl = scl_out;
      st.sda_pull_low = !sda_released;
      st.busy = master_phase != i2cm_pkg::PH_IDLE;
      st.done = finished;
      st.read_data = received_byte;
      st.ack_failed = ack_timed_out;
      return st;
   endfunction

   // Device ticks are filled in from the model state just before they go out,
   // so the device answers acknowledge polls and makes noise while busy.
   function automatic tick_item_type fill_device_tick(input tick_item_type t);
      tick_item_type r;
      r = t;
      if (t.kind == KIND_DEVICE) begin
         r.func = (master_phase == i2cm_pkg::PH_IDLE) ? i2cm_pkg::FUNC_TICK
                                                     : 2'($urandom_range(0, 3));
         r.device_address = 8'($urandom);
         r.register_address = 8'($urandom);
         r.write_data = 8'($urandom);
         if (master_phase == i2cm_pkg::PH_ACK_POLL) begin
            case (device_ack)
               ACK_AT_ONCE: r.sda = 1'b0;
               ACK_LATE:    r.sda = 1'($urandom_range(0, 1));
               default:     r.sda = 1'b1;
            endcase
         end else begin
            r.sda = 1'($urandom_range(0, 1));
         end
      end
      return r;
   endfunction

   // Sender.
   tick_item_type   drive_item = '0;
   logic            drive_held = 1'b0;
   int              drive_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         drive_held = 1'b0;
         drive_gap = 0;
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_status.push_back(advance_master(drive_item));
            drive_held = 1'b0;
         end
         if (!drive_held && pending_ticks.size() > 0) begin
            if (drive_gap > 0) begin
               drive_gap--;
            end else if (!steady && $urandom_range(0, 23) == 0) begin
               drive_gap = $urandom_range(0, 11);
            end else begin
               drive_item = fill_device_tick(pending_ticks.pop_front());
               drive_held = 1'b1;
            end
         end
         req_valid <= drive_held;
         req_func <= drive_item.func;
         req_device_address <= drive_item.device_address;
         req_register_address <= drive_item.register_address;
         req_write_data <= drive_item.write_data;
         req_sda_sample <= drive_item.sda;
      end
   end

   function automatic void report_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
   endfunction

   // Receiver and checker.
   int               status_beats = 0;
   int               accept_gap = 0;
   int               long_hold_left = 0;
   logic             long_hold_done = 1'b0;
   bus_status_type   want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            status_beats++;
            if (expected_status.size() == 0) begin
               mismatches++;
               $display("%0t: status beat with none expected", $time);
            end else begin
               want = expected_status.pop_front();
               report_field("scl_level", want.scl, rsp_scl_level);
               report_field("sda_pull_low", want.sda_pull_low, rsp_sda_pull_low);
               report_field("busy_res", want.busy, rsp_busy_res);
               report_field("done_res", want.done, rsp_done_res);
               report_field("read_data", want.read_data, rsp_read_data);
               report_field("ack_failed", want.ack_failed, rsp_ack_failed);
            end
         end
         // One long hold-off while the sender keeps offering beats, so the
         // master fills up and stalls its input.
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && status_beats >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (accept_gap > 0) begin
            accept_gap--;
            rsp_ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 19) == 0) begin
            accept_gap = $urandom_range(0, 11);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL i2c_master_register_access");
            $finish;
         end
      end
   end

   // Stimulus sequencing runs on the falling edge, away from the samplers.
   function automatic void push_tick(input item_kind_type kind, input logic [1:0] func,
                                     input logic [7:0] dev, input logic [7:0] regis,
                                     input logic [7:0] data, input logic sda);
      tick_item_type t;
      t.kind = kind;
      t.func = func;
      t.device_address = dev;
      t.register_address = regis;
      t.write_data = data;
      t.sda = sda;
      pending_ticks.push_back(t);
      ticks_queued++;
   endfunction

   task automatic feed_until_idle();
      do begin
         repeat (16) push_tick(KIND_DEVICE, i2cm_pkg::FUNC_TICK, '0, '0, '0, 1'b0);
         do @(negedge clock); while (pending_ticks.size() > 2);
      end while (master_phase != i2cm_pkg::PH_IDLE);
   endtask

   task automatic run_transaction(input logic [1:0] func, input logic [7:0] dev,
                                  input logic [7:0] regis, input logic [7:0] data,
                                  input ack_style_type style);
      device_ack = style;
      push_tick(KIND_REQUEST, func, dev, regis, data, 1'b1);
      feed_until_idle();
   endtask

   // Waits until every beat has gone through and every status has come back.
   task automatic drain();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_valid || expected_status.size() != 0);
   endtask

   task automatic write_csr(input logic index, input logic [i2cm_pkg::CSR_WIDTH-1:0] value);
      drain();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == i2cm_pkg::CSR_TICKS_PER_US)
         tpu_setting = value;
      else
         poll_limit_setting = value[i2cm_pkg::LIMIT_WIDTH-1:0];
   endtask

   task automatic random_traffic(input int count);
      int first;
      int pick;
      ack_style_type style;
      first = ticks_queued;
      while (ticks_queued - first < count) begin
         if ($urandom_range(0, 6) == 0) begin
            // Raw noise may start a transaction with random line samples.
            device_ack = ACK_LATE;
            repeat ($urandom_range(1, 8))
               push_tick(KIND_RAW, 2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                         8'($urandom), 1'($urandom_range(0, 1)));
            feed_until_idle();
         end else begin
            pick = $urandom_range(0, 9);
            style = (pick < 5) ? ACK_AT_ONCE : (pick < 9) ? ACK_LATE : ACK_NEVER;
            run_transaction($urandom_range(0, 1) ? i2cm_pkg::FUNC_WRITE : i2cm_pkg::FUNC_READ,
                            8'($urandom), 8'($urandom), 8'($urandom), style);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: address and data extremes, address wrap on a read,
      // an acknowledge timeout at the reset limit, the unused code and a bare tick.
      run_transaction(i2cm_pkg::FUNC_WRITE, 8'h00, 8'hFF, 8'hA5, ACK_AT_ONCE);
      run_transaction(i2cm_pkg::FUNC_READ, 8'hFF, 8'h00, 8'hFF, ACK_LATE);
      run_transaction(i2cm_pkg::FUNC_WRITE, 8'h7E, 8'h81, 8'h00, ACK_NEVER);
      run_transaction(2'd3, 8'hFF, 8'hFF, 8'hFF, ACK_AT_ONCE);
      run_transaction(i2cm_pkg::FUNC_TICK, 8'hFF, 8'hFF, 8'hFF, ACK_AT_ONCE);

      // A zero unit acts as one tick; a zero limit fails on the first high poll.
      write_csr(i2cm_pkg::CSR_TICKS_PER_US, 10'd0);
      write_csr(i2cm_pkg::CSR_ACK_POLL_LIMIT, 10'd0);
      random_traffic(150);

      write_csr(i2cm_pkg::CSR_TICKS_PER_US, 10'd3);
      write_csr(i2cm_pkg::CSR_ACK_POLL_LIMIT, 10'd1);
      random_traffic(150);

      write_csr(i2cm_pkg::CSR_TICKS_PER_US, 10'd1);
      write_csr(i2cm_pkg::CSR_ACK_POLL_LIMIT, 10'd255);
      steady = 1'b1;
      random_traffic(200);

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("PASS i2c_master_register_access");
      else
         $display("FAIL i2c_master_register_access");
      $finish;
   end

endmodule
